FILE: hdl/lovs_pkg.sv
// Package for label overlap statistics: sizes, codes, table entry types and counter helpers.
`timescale 1ns / 1ps
`default_nettype none

package lovs_pkg;

  // Label space and counter sizes
  localparam int unsigned FG_LABELS   = 256;
  localparam int unsigned BG_LABELS   = 256;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned LABEL_BITS  = 8;
  localparam int unsigned OUT_BITS    = 32;
  localparam int unsigned REGION_BITS = 9;

  // Only labels that fit in a label field get a table slot
  localparam int unsigned FG_SLOTS  = (FG_LABELS < 256) ? FG_LABELS : 256;
  localparam int unsigned BG_SLOTS  = (BG_LABELS < 256) ? BG_LABELS : 256;
  localparam int unsigned FG_AW     = $clog2(FG_SLOTS);
  localparam int unsigned BG_AW     = $clog2(BG_SLOTS);
  localparam int unsigned CLR_DEPTH = (FG_SLOTS > BG_SLOTS) ? FG_SLOTS : BG_SLOTS;
  localparam int unsigned CLR_AW    = $clog2(CLR_DEPTH);

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_VOXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // One entry of the foreground table
  typedef struct packed {
    logic [COUNT_BITS-1:0] size;
    logic [COUNT_BITS-1:0] ovl;
    logic [LABEL_BITS-1:0] host;
  } fg_entry_t;

  typedef struct packed {
    logic                  we;
    logic [FG_AW-1:0]      waddr;
    fg_entry_t             wdata;
    logic                  re;
    logic [FG_AW-1:0]      raddr;
  } fg_req_t;

  typedef struct packed {
    logic                   we;
    logic [BG_AW-1:0]       waddr;
    logic [REGION_BITS-1:0] wdata;
    logic                   re;
    logic [BG_AW-1:0]       raddr;
  } bg_req_t;

  // Seen bits: one row per foreground label, one bit per background label
  typedef struct packed {
    logic                we;
    logic [FG_AW-1:0]    waddr;
    logic [BG_SLOTS-1:0] wdata;
    logic                re;
    logic [FG_AW-1:0]    raddr;
  } seen_req_t;

  typedef struct packed {
    logic                   load;
    logic [OUT_BITS-1:0]    size;
    logic [OUT_BITS-1:0]    ovl;
    logic [LABEL_BITS-1:0]  host;
    logic [REGION_BITS-1:0] objs;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic exec;
  } stat_t;

  // Saturating increment of a wide counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v != '1) ? v + COUNT_BITS'(1) : v;
  endfunction

  // Clip a counter to the output field width
  function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    return (v > COUNT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/label_overlap_statistics.sv
// Top level of label overlap statistics: table memories, sequencer and result register.
// Counts per foreground label its voxels and, for a nonzero label, its voxels on nonzero
// background, records per (nonzero foreground, background) pair whether it has been met,
// counts per background label the distinct nonzero foreground labels met in it, and keeps
// for each nonzero foreground label the background label last newly paired with it. A voxel
// word and a read word first read the table memories, then write back or load the result
// register (a read waits there while the result register is still full). A clear word, and
// reset, sweep all tables one address per cycle, during which in_ready_o is low.
// Unused command codes are taken and dropped. A read result stays in the output register
// while the next words are taken.
`timescale 1ns / 1ps
`default_nettype none

module label_overlap_statistics import lovs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [LABEL_BITS-1:0]  fg_label_i,
  input  wire logic [LABEL_BITS-1:0]  bg_label_i,
  input  wire logic [LABEL_BITS-1:0]  read_index_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [OUT_BITS-1:0]         object_size_o,
  output logic [OUT_BITS-1:0]         overlap_count_o,
  output logic [LABEL_BITS-1:0]       host_region_o,
  output logic [REGION_BITS-1:0]      objects_in_region_o
);

  fg_req_t                fg_req;
  bg_req_t                bg_req;
  seen_req_t              seen_req;
  fg_entry_t              fg_rdata;
  logic [REGION_BITS-1:0] bg_rdata;
  logic [BG_SLOTS-1:0]    seen_rdata;
  res_t                   res;
  stat_t                  stat;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]    size_q, ovl_q;
  logic [LABEL_BITS-1:0]  host_q;
  logic [REGION_BITS-1:0] objs_q;
  logic                   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  lovs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .fg_label_i   (fg_label_i),
    .bg_label_i   (bg_label_i),
    .read_index_i (read_index_i),
    .out_free_i   (out_free),
    .fg_req_o     (fg_req),
    .fg_rdata_i   (fg_rdata),
    .bg_req_o     (bg_req),
    .bg_rdata_i   (bg_rdata),
    .seen_req_o   (seen_req),
    .seen_rdata_i (seen_rdata),
    .res_o        (res),
    .stat_o       (stat)
  );

  // Size, overlap and host per foreground label
  lovs_ram #(
    .WIDTH ($bits(fg_entry_t)),
    .DEPTH (FG_SLOTS)
  ) u_fg_ram (
    .clk_i   (clk_i),
    .we_i    (fg_req.we),
    .waddr_i (fg_req.waddr),
    .wdata_i (fg_req.wdata),
    .re_i    (fg_req.re),
    .raddr_i (fg_req.raddr),
    .rdata_o (fg_rdata)
  );

  // Object count per background label
  lovs_ram #(
    .WIDTH (REGION_BITS),
    .DEPTH (BG_SLOTS)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (bg_req.we),
    .waddr_i (bg_req.waddr),
    .wdata_i (bg_req.wdata),
    .re_i    (bg_req.re),
    .raddr_i (bg_req.raddr),
    .rdata_o (bg_rdata)
  );

  // Pair seen bits, one row per foreground label
  lovs_ram #(
    .WIDTH (BG_SLOTS),
    .DEPTH (FG_SLOTS)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_req.we),
    .waddr_i (seen_req.waddr),
    .wdata_i (seen_req.wdata),
    .re_i    (seen_req.re),
    .raddr_i (seen_req.raddr),
    .rdata_o (seen_rdata)
  );

  // Result register: load a read result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      size_q <= res.size;
      ovl_q  <= res.ovl;
      host_q <= res.host;
      objs_q <= res.objs;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign object_size_o       = size_q;
  assign overlap_count_o     = ovl_q;
  assign host_region_o       = host_q;
  assign objects_in_region_o = objs_q;

  // A word with a valid command keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (command_i == CMD_VOXEL || command_i == CMD_READ || command_i == CMD_CLEAR))
    |=> !in_ready_o)
    else $error("input open right after a command word");

  // A result is loaded only into a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // Outside the clear sweep, object counts move only with a new seen bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.clearing |-> (bg_req.we == seen_req.we))
    else $error("object count and seen bit written apart");

  // No word is taken during the clear sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !in_ready_o)
    else $error("input open during clear sweep");

  // No word is taken while a word is being executed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.exec |-> !in_ready_o)
    else $error("input open while a word executes");

endmodule

`default_nettype wire

FILE: hdl/lovs_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lovs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lovs_ctrl.sv
// Sequencer: clear sweep, table reads, read-modify-write of voxel updates, read results.
`timescale 1ns / 1ps
`default_nettype none

module lovs_ctrl import lovs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [LABEL_BITS-1:0]  fg_label_i,
  input  wire logic [LABEL_BITS-1:0]  bg_label_i,
  input  wire logic [LABEL_BITS-1:0]  read_index_i,
  input  wire logic                   out_free_i,
  output fg_req_t                     fg_req_o,
  input  wire fg_entry_t              fg_rdata_i,
  output bg_req_t                     bg_req_o,
  input  wire logic [REGION_BITS-1:0] bg_rdata_i,
  output seen_req_t                   seen_req_o,
  input  wire logic [BG_SLOTS-1:0]    seen_rdata_i,
  output res_t                        res_o,
  output stat_t                       stat_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q, state_d;
  logic [CLR_AW-1:0]     clr_cnt_q, clr_cnt_d;
  cmd_e                  cmd_q, cmd_d;
  logic [LABEL_BITS-1:0] fg_q, fg_d;
  logic [LABEL_BITS-1:0] bg_q, bg_d;
  logic                  fg_ok_q, fg_ok_d;
  logic                  bg_ok_q, bg_ok_d;

  logic                  accept;
  logic                  in_fg_ok, in_bg_ok;
  logic [LABEL_BITS-1:0] fg_addr, bg_addr;
  logic [BG_AW-1:0]      bg_bit;
  logic                  first_pair;
  fg_entry_t             fg_upd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Range of the incoming labels, for a voxel or a read index
  always_comb begin
    fg_addr = (command_i == CMD_READ) ? read_index_i : fg_label_i;
    bg_addr = (command_i == CMD_READ) ? read_index_i : bg_label_i;
    in_fg_ok = {1'b0, fg_addr} < (LABEL_BITS+1)'(FG_SLOTS);
    in_bg_ok = {1'b0, bg_addr} < (LABEL_BITS+1)'(BG_SLOTS);
  end

  // Modify step of a voxel update
  always_comb begin
    bg_bit     = bg_q[BG_AW-1:0];
    first_pair = (fg_q != '0) && !seen_rdata_i[bg_bit];
    fg_upd.size = sat_inc(fg_rdata_i.size);
    fg_upd.ovl  = ((fg_q != '0) && (bg_q != '0)) ? sat_inc(fg_rdata_i.ovl) : fg_rdata_i.ovl;
    fg_upd.host = first_pair ? bg_q : fg_rdata_i.host;
  end

  // Next state, memory requests and result
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cmd_d     = cmd_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    fg_ok_d   = fg_ok_q;
    bg_ok_d   = bg_ok_q;

    fg_req_o   = '0;
    bg_req_o   = '0;
    seen_req_o = '0;
    res_o      = '0;

    // Read ports follow the incoming word
    fg_req_o.raddr   = fg_addr[FG_AW-1:0];
    bg_req_o.raddr   = bg_addr[BG_AW-1:0];
    seen_req_o.raddr = fg_label_i[FG_AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        fg_req_o.we      = {1'b0, clr_cnt_q} < (CLR_AW+1)'(FG_SLOTS);
        fg_req_o.waddr   = clr_cnt_q[FG_AW-1:0];
        bg_req_o.we      = {1'b0, clr_cnt_q} < (CLR_AW+1)'(BG_SLOTS);
        bg_req_o.waddr   = clr_cnt_q[BG_AW-1:0];
        seen_req_o.we    = fg_req_o.we;
        seen_req_o.waddr = clr_cnt_q[FG_AW-1:0];
        if (clr_cnt_q == CLR_AW'(CLR_DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CLR_AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          fg_d    = fg_label_i;
          bg_d    = bg_label_i;
          fg_ok_d = in_fg_ok;
          bg_ok_d = in_bg_ok;
          unique case (command_i)
            CMD_VOXEL: begin
              cmd_d = CMD_VOXEL;
              fg_req_o.re   = 1'b1;
              bg_req_o.re   = 1'b1;
              seen_req_o.re = 1'b1;
              state_d = ST_EXEC;
            end
            CMD_READ: begin
              cmd_d = CMD_READ;
              fg_req_o.re = 1'b1;
              bg_req_o.re = 1'b1;
              state_d = ST_EXEC;
            end
            CMD_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (cmd_q == CMD_VOXEL) begin
          // Write back; a voxel with an out-of-range label is dropped
          if (fg_ok_q && bg_ok_q) begin
            fg_req_o.we      = 1'b1;
            fg_req_o.waddr   = fg_q[FG_AW-1:0];
            fg_req_o.wdata   = fg_upd;
            seen_req_o.we    = first_pair;
            seen_req_o.waddr = fg_q[FG_AW-1:0];
            seen_req_o.wdata = seen_rdata_i | (BG_SLOTS'(1) << bg_bit);
            bg_req_o.we      = first_pair;
            bg_req_o.waddr   = bg_bit;
            bg_req_o.wdata   = (bg_rdata_i != '1) ? bg_rdata_i + REGION_BITS'(1) : bg_rdata_i;
          end
          state_d = ST_IDLE;
        end else if (out_free_i) begin
          res_o.load = 1'b1;
          res_o.size = fg_ok_q ? clip_out(fg_rdata_i.size) : '0;
          res_o.ovl  = fg_ok_q ? clip_out(fg_rdata_i.ovl) : '0;
          res_o.host = fg_ok_q ? fg_rdata_i.host : '0;
          res_o.objs = bg_ok_q ? bg_rdata_i : '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.exec     = (state_q == ST_EXEC);

  // Hold state and the captured word; reset starts a clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cmd_q     <= CMD_VOXEL;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fg_q    <= fg_d;
    bg_q    <= bg_d;
    fg_ok_q <= fg_ok_d;
    bg_ok_q <= bg_ok_d;
  end

endmodule

`default_nettype wire
